[hdl/nhlt_pkg.sv]
// Types, codes and counter update functions for the node heartbeat liveness table.
// No dependencies; used by nhlt_mem, nhlt_ctrl and the top level.
package nhlt_pkg;

  localparam int unsigned CNT_PER_NODE = 10;

  typedef logic [7:0] cnt_t;
  typedef logic [CNT_PER_NODE-1:0][7:0] entry_t;

  localparam logic [1:0] REQ_HB    = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [3:0] T_RUN       = 4'd0;
  localparam logic [3:0] T_STOP      = 4'd1;
  localparam logic [3:0] T_SYNC      = 4'd2;
  localparam logic [3:0] T_STANDBY   = 4'd3;
  localparam logic [3:0] T_HOST      = 4'd4;
  localparam logic [3:0] T_LINK0     = 4'd5;
  localparam logic [3:0] T_LINK1     = 4'd6;
  localparam logic [3:0] T_DBRUN     = 4'd7;
  localparam logic [3:0] T_DBSTOP    = 4'd8;
  localparam logic [3:0] T_DBSTANDBY = 4'd9;
  localparam logic [3:0] T_NONE      = 4'd15;
  localparam logic [3:0] T_LAST      = T_DBSTANDBY;

  localparam cnt_t HOLD_RESET = 8'd150;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // map a message kind to its counter slot
  function automatic logic [3:0] kind_slot(input logic [3:0] kind);
    logic [3:0] slot;
    case (kind)
      4'd0:    slot = T_RUN;
      4'd1:    slot = T_STOP;
      4'd2:    slot = T_SYNC;
      4'd3:    slot = T_STANDBY;
      4'd4:    slot = T_HOST;
      4'd5:    slot = T_DBRUN;
      4'd6:    slot = T_DBSTOP;
      4'd7:    slot = T_DBSTANDBY;
      default: slot = T_NONE;
    endcase
    return slot;
  endfunction

  function automatic entry_t hb_update(input entry_t e, input logic lnk,
                                       input logic [3:0] kind, input cnt_t hold);
    entry_t     r;
    logic [3:0] slot;
    r    = e;
    slot = kind_slot(kind);
    if (lnk) begin
      r[T_LINK1] = hold;
    end else begin
      r[T_LINK0] = hold;
    end
    r[T_RUN]     = '0;
    r[T_STOP]    = '0;
    r[T_SYNC]    = '0;
    r[T_STANDBY] = '0;
    if (slot != T_NONE) begin
      r[slot] = hold;
    end
    return r;
  endfunction

  function automatic entry_t tick_update(input entry_t e);
    entry_t r;
    for (int c = 0; c < CNT_PER_NODE; c++) begin
      r[c] = (e[c] != '0) ? e[c] - 8'd1 : e[c];
    end
    return r;
  endfunction

endpackage

[hdl/node_heartbeat_liveness_table_core.sv]
// Top level of the node heartbeat liveness table: config register, sequencer, store.
// Depends on nhlt_pkg, nhlt_ctrl and nhlt_mem.
//
//  channel   | handshake                  | word
//  ----------+----------------------------+---------------------------------------------
//  request   | start / busy               | req_type_i link_i node_addr_i msg_kind_i
//            |                            | query_table_i
//  result    | result_valid_o (strobe)    | counter_value_o
//  config    | cfg_we_i                   | cfg_hold_count_i
//
//  Heartbeat: the entry is read (ST_HB_RD), then written back updated (ST_HB_WR).
//  Query: the entry is read (ST_Q_RD), then the counter and strobe are registered (ST_Q_OUT).
//  Tick: one pass over the store with read and write-back
//  overlapped. Ignored requests and out-of-range nodes/tables return to idle at once.
//  Reset: a clearing pass writes every entry to zero; busy holds high.
//  The receiver cannot stall: each result stands for exactly one cycle.
module node_heartbeat_liveness_table_core
  import nhlt_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic       link_i,
  input  logic [7:0] node_addr_i,
  input  logic [3:0] msg_kind_i,
  input  logic [3:0] query_table_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_hold_count_i,
  output logic       result_valid_o,
  output logic [7:0] counter_value_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  cnt_t          hold_count_q;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_count_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_count_q <= cfg_hold_count_i;
    end
  end

  nhlt_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .req_type_i      (req_type_i),
    .link_i          (link_i),
    .node_addr_i     (node_addr_i),
    .msg_kind_i      (msg_kind_i),
    .query_table_i   (query_table_i),
    .hold_count_i    (hold_count_q),
    .mem_ctl_o       (mem_ctl),
    .rd_addr_o       (rd_addr),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_data_i       (rd_data),
    .result_valid_o  (result_valid_o),
    .counter_value_o (counter_value_o)
  );

  nhlt_mem #(
    .DEPTH (NODE_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule

[hdl/nhlt_mem.sv]
// Counter store: one entry of ten counters per node, one write and one read port.
// Read data is registered. Depends on nhlt_pkg.
module nhlt_mem
  import nhlt_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  mem_ctl_t      ctl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/nhlt_ctrl.sv]
// Sequencer: clearing pass, heartbeat read-modify-write, query read, tick sweep.
// Drives nhlt_mem through mem_ctl_t; depends on nhlt_pkg.
module nhlt_ctrl
  import nhlt_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 256,
  parameter int unsigned AW         = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    req_type_i,
  input  logic          link_i,
  input  logic [7:0]    node_addr_i,
  input  logic [3:0]    msg_kind_i,
  input  logic [3:0]    query_table_i,
  input  cnt_t          hold_count_i,
  output mem_ctl_t      mem_ctl_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o,
  output entry_t        wr_data_o,
  input  entry_t        rd_data_i,
  output logic          result_valid_o,
  output cnt_t          counter_value_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HB_RD = 3'd2;
  localparam logic [2:0] ST_HB_WR = 3'd3;
  localparam logic [2:0] ST_Q_RD  = 3'd4;
  localparam logic [2:0] ST_Q_OUT = 3'd5;
  localparam logic [2:0] ST_TICK  = 3'd6;

  localparam logic [AW:0] SWEEP_END  = (AW+1)'(NODE_COUNT);
  localparam logic [AW:0] CLEAR_LAST = (AW+1)'(NODE_COUNT - 1);

  logic [2:0]    state_q, state_d;
  logic [AW:0]   sweep_q, sweep_d;
  logic [AW-1:0] node_q, node_d;
  logic          link_q, link_d;
  logic [3:0]    kind_q, kind_d;
  logic [3:0]    tab_q, tab_d;
  logic          res_valid_q, res_valid_d;
  cnt_t          value_q, value_d;
  logic          accept;
  logic          in_range;
  logic [AW:0]   sweep_prev;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign in_range   = 32'(node_addr_i) < NODE_COUNT;
  assign sweep_prev = sweep_q - (AW+1)'(1);
  assign busy_o     = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    node_d      = node_q;
    link_d      = link_q;
    kind_d      = kind_q;
    tab_d       = tab_q;
    res_valid_d = 1'b0;
    value_d     = value_q;
    mem_ctl_o   = '0;
    rd_addr_o   = node_q;
    wr_addr_o   = node_q;
    wr_data_o   = hb_update(rd_data_i, link_q, kind_q, hold_count_i);

    case (state_q)
      ST_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = sweep_q[AW-1:0];
        wr_data_o       = '0;
        sweep_d         = sweep_q + (AW+1)'(1);
        if (sweep_q == CLEAR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          node_d = AW'(node_addr_i);
          link_d = link_i;
          kind_d = msg_kind_i;
          tab_d  = query_table_i;
          case (req_type_i)
            REQ_HB: begin
              if (in_range) begin
                state_d = ST_HB_RD;
              end
            end
            REQ_TICK: begin
              sweep_d = '0;
              state_d = ST_TICK;
            end
            REQ_QUERY: begin
              if (query_table_i <= T_LAST) begin
                if (in_range) begin
                  state_d = ST_Q_RD;
                end else begin
                  // node beyond the table answers zero
                  res_valid_d = 1'b1;
                  value_d     = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_HB_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        state_d         = ST_HB_WR;
      end
      ST_HB_WR: begin
        mem_ctl_o.wr_en = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_Q_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        state_d         = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        res_valid_d = 1'b1;
        value_d     = rd_data_i[tab_q];
        state_d     = ST_IDLE;
      end
      ST_TICK: begin
        // read entry n while writing back entry n-1
        mem_ctl_o.rd_en = (sweep_q != SWEEP_END);
        mem_ctl_o.wr_en = (sweep_q != '0);
        rd_addr_o       = sweep_q[AW-1:0];
        wr_addr_o       = sweep_prev[AW-1:0];
        wr_data_o       = tick_update(rd_data_i);
        sweep_d         = sweep_q + (AW+1)'(1);
        if (sweep_q == SWEEP_END) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    link_q  <= link_d;
    kind_q  <= kind_d;
    tab_q   <= tab_d;
    value_q <= value_d;
  end

  assign result_valid_o  = res_valid_q;
  assign counter_value_o = value_q;

  a_hb_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HB_WR |-> $past(state_q) == ST_HB_RD && $past(mem_ctl_o.rd_en))
    else $error("heartbeat write-back without a preceding read");

  a_q_out_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_Q_OUT |-> $past(mem_ctl_o.rd_en) && $past(rd_addr_o) == node_q)
    else $error("query result taken without a read of its node");

  a_tick_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl_o.rd_en && mem_ctl_o.wr_en) |-> rd_addr_o != wr_addr_o)
    else $error("read and write-back hit the same entry");

  a_result_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == ST_Q_OUT || $past(state_q) == ST_IDLE)
    else $error("result strobe outside a query");

endmodule
